@@ hdl/vdpt_pkg.sv @@
package vdpt_pkg;

	localparam int CYCLES_PER_LINE_DEF = 228;

	localparam int VRAM_DEPTH = 16384;
	localparam int VRAM_AW    = $clog2(VRAM_DEPTH);

	localparam int MODE_W = 3;
	localparam logic [MODE_W-1:0] MODE_CTRL_WR = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DATA_WR = 3'd1;
	localparam logic [MODE_W-1:0] MODE_STAT_RD = 3'd2;
	localparam logic [MODE_W-1:0] MODE_DATA_RD = 3'd3;
	localparam logic [MODE_W-1:0] MODE_TICK    = 3'd4;

	localparam logic [1:0] CODE_VRAM_RD = 2'd0;
	localparam logic [1:0] CODE_VRAM_WR = 2'd1;
	localparam logic [1:0] CODE_REG_WR  = 2'd2;
	localparam logic [1:0] CODE_CRAM_WR = 2'd3;

	localparam int NUM_REGS = 11;
	localparam logic [3:0] REG_MODE1    = 4'd0;
	localparam logic [3:0] REG_MODE2    = 4'd1;
	localparam logic [3:0] REG_LINE_CNT = 4'd10;
	localparam logic [7:0] REG_RESET [NUM_REGS] = '{
		8'h36, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFB, 8'hFF, 8'hFF, 8'hFF, 8'hFF
	};

	localparam logic [4:0] STATUS_FIXED = 5'h1F;

	localparam logic [8:0] LINE_ACTIVE_LAST = 9'd192;
	localparam logic [8:0] LINE_VBL_FIRST   = 9'd193;
	localparam logic [8:0] LINE_FRAME_IRQ   = 9'd196;
	localparam logic [8:0] LINE_JUMP        = 9'd218;
	localparam logic [8:0] LINE_RELOAD_LAST = 9'd261;
	localparam logic [8:0] LINE_WRAP        = 9'd262;
	localparam logic [7:0] VCOUNT_JUMP      = 8'd213;
	localparam logic [8:0] ACCUM_MAX        = 9'h1FF;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_line;
		logic [7:0] vcount_value;
		logic       frame_done;
	} result_t;

	typedef struct packed {
		logic       frame_irq_now;
		logic       line_irq;
		logic       frame_irq;
		logic [7:0] vcount;
		logic       done;
	} line_stat_t;

endpackage

@@ hdl/vdpt_if.sv @@
interface vdpt_in_if;
	import vdpt_pkg::*;

	logic              valid;
	logic              ready;
	logic [MODE_W-1:0] mode;
	logic [7:0]        value;
	logic [7:0]        tick_cycles;

	modport source (output valid, output mode, output value, output tick_cycles, input ready);
	modport sink (input valid, input mode, input value, input tick_cycles, output ready);
endinterface

interface vdpt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_data;
	logic       irq_line;
	logic [7:0] vcount_value;
	logic       frame_done;

	modport source (output valid, output read_data, output irq_line, output vcount_value,
		output frame_done, input ready);
	modport sink (input valid, input read_data, input irq_line, input vcount_value,
		input frame_done, output ready);
endinterface

@@ hdl/vdpt_vram.sv @@
module vdpt_vram (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic                        wr_en,
	input  logic [vdpt_pkg::VRAM_AW-1:0] addr,
	input  logic [7:0]                  wdata,
	output logic [7:0]                  rdata,
	output logic                        busy
);
	import vdpt_pkg::*;

	logic [7:0]         mem [VRAM_DEPTH];
	logic [VRAM_AW-1:0] clr_addr_q;
	logic               busy_q;

	// After reset the whole array is swept to zero, one entry a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			busy_q     <= 1'b1;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (&clr_addr_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata <= mem[addr];
		end
	end

	assign busy = busy_q;
endmodule

@@ hdl/vdpt_line_timer.sv @@
module vdpt_line_timer #(
	parameter int CYCLES_PER_LINE = vdpt_pkg::CYCLES_PER_LINE_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   tick,
	input  logic                   clr_pending,
	input  logic [7:0]             cycles,
	input  logic [7:0]             reload,
	output vdpt_pkg::line_stat_t   stat
);
	import vdpt_pkg::*;

	localparam logic [8:0] CPL = 9'(CYCLES_PER_LINE);

	logic [8:0] accum_q, accum_n;
	logic [8:0] line_q, line_n, line_inc;
	logic [7:0] vcount_q, vcount_n;
	logic [7:0] cd_q, cd_n;
	logic       lirq_q, lirq_n;
	logic       firq_q, firq_n;
	logic       done;
	logic [9:0] sum;
	logic [8:0] sat;

	always_comb begin
		sum      = {1'b0, accum_q} + 10'(cycles);
		sat      = (sum > 10'(ACCUM_MAX)) ? ACCUM_MAX : sum[8:0];
		line_inc = line_q + 9'd1;
		accum_n  = accum_q;
		line_n   = line_q;
		vcount_n = vcount_q;
		cd_n     = cd_q;
		lirq_n   = lirq_q;
		firq_n   = firq_q;
		done     = 1'b0;
		if (tick) begin
			accum_n = sat;
			if (sat >= CPL) begin
				accum_n = sat - CPL;
				if (line_q <= LINE_ACTIVE_LAST) begin
					if (cd_q == 8'd0) begin
						cd_n   = reload;
						lirq_n = 1'b1;
					end else begin
						cd_n = cd_q - 8'd1;
					end
				end
				line_n   = line_inc;
				vcount_n = vcount_q + 8'd1;
				if (line_inc inside {[LINE_VBL_FIRST:LINE_RELOAD_LAST]}) begin
					cd_n = reload;
				end
				if (line_inc == LINE_FRAME_IRQ) begin
					firq_n = 1'b1;
				end else if (line_inc == LINE_JUMP) begin
					vcount_n = VCOUNT_JUMP;
				end else if (line_inc == LINE_WRAP) begin
					done     = 1'b1;
					line_n   = '0;
					vcount_n = '0;
				end
			end
		end
		if (clr_pending) begin
			lirq_n = 1'b0;
			firq_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q  <= '0;
			line_q   <= '0;
			vcount_q <= '0;
			cd_q     <= 8'hFF;
			lirq_q   <= 1'b0;
			firq_q   <= 1'b0;
		end else if (en) begin
			accum_q  <= accum_n;
			line_q   <= line_n;
			vcount_q <= vcount_n;
			cd_q     <= cd_n;
			lirq_q   <= lirq_n;
			firq_q   <= firq_n;
		end
	end

	assign stat.frame_irq_now = firq_q;
	assign stat.line_irq      = lirq_n;
	assign stat.frame_irq     = firq_n;
	assign stat.vcount        = vcount_n;
	assign stat.done          = done;
endmodule

@@ hdl/vdpt_out_buf.sv @@
module vdpt_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vdpt_pkg::result_t   din,
	output logic                full,
	vdpt_out_if.source          out_item
);
	import vdpt_pkg::*;

	result_t head_q, skid_q;
	logic    head_vld_q, skid_vld_q;
	logic    pop;

	assign pop = out_item.valid && out_item.ready;

	// Two entries, so the input side waits on the output ready only once both are full.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			if (head_vld_q) begin
				skid_vld_q <= 1'b1;
			end else begin
				head_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && skid_vld_q) begin
			head_q <= skid_q;
		end else if (push && (pop || !head_vld_q)) begin
			head_q <= din;
		end
		if (push && !pop && head_vld_q) begin
			skid_q <= din;
		end
	end

	assign full                  = skid_vld_q;
	assign out_item.valid        = head_vld_q;
	assign out_item.read_data    = head_q.read_data;
	assign out_item.irq_line     = head_q.irq_line;
	assign out_item.vcount_value = head_q.vcount_value;
	assign out_item.frame_done   = head_q.frame_done;
endmodule

@@ hdl/video_chip_port_and_line_timing.sv @@
// The result of an item is registered in the output buffer when its input beat is accepted.
// Throughput: one item per cycle while the output buffer is not full; each item does
// at most one VRAM access, and registered VRAM read data is the next data read's buffer.
// Reset: arst_n resets all control state; the VRAM is then swept to zero at one entry
// a cycle, during which ready stays low.
module video_chip_port_and_line_timing #(
	parameter int CYCLES_PER_LINE = vdpt_pkg::CYCLES_PER_LINE_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	vdpt_in_if.sink      in_item,
	vdpt_out_if.source   out_item
);
	import vdpt_pkg::*;

	logic [VRAM_AW-1:0] addr_q;
	logic [1:0]         code_q;
	logic               second_q;
	logic               target_vram_q;
	logic [7:0]         buf_q;
	logic               buf_mem_q;
	logic [7:0]         regs_q [NUM_REGS];

	logic               acc, busy, full;
	logic               is_ctrl, is_dwr, is_srd, is_drd, is_tick;
	logic               ctrl_second;
	logic [1:0]         new_code;
	logic [VRAM_AW-1:0] new_addr, vram_addr;
	logic               vram_rd, vram_wr;
	logic [7:0]         vram_rdata, buf_now;
	logic               reg_we;
	logic [3:0]         reg_idx;
	logic               r0_b4, r1_b5;
	line_stat_t         tstat;
	result_t            res;

	assign acc     = in_item.valid && in_item.ready;
	assign is_ctrl = in_item.mode == MODE_CTRL_WR;
	assign is_dwr  = in_item.mode == MODE_DATA_WR;
	assign is_srd  = in_item.mode == MODE_STAT_RD;
	assign is_drd  = in_item.mode == MODE_DATA_RD;
	assign is_tick = in_item.mode == MODE_TICK;

	assign ctrl_second = is_ctrl && second_q;
	assign new_code    = in_item.value[7:6];
	assign new_addr    = {in_item.value[5:0], addr_q[7:0]};
	assign vram_addr   = ctrl_second ? new_addr : addr_q;
	assign vram_rd     = acc && (is_drd || (ctrl_second && new_code == CODE_VRAM_RD));
	assign vram_wr     = acc && is_dwr && target_vram_q;
	assign reg_idx     = in_item.value[3:0];
	assign reg_we      = acc && ctrl_second && new_code == CODE_REG_WR
		&& reg_idx < 4'(NUM_REGS);

	// The read buffer lives in the VRAM read register until a data write replaces it.
	assign buf_now = buf_mem_q ? vram_rdata : buf_q;

	assign in_item.ready = !busy && !full;

	vdpt_vram u_vram (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (vram_rd),
		.wr_en  (vram_wr),
		.addr   (vram_addr),
		.wdata  (in_item.value),
		.rdata  (vram_rdata),
		.busy   (busy)
	);

	vdpt_line_timer #(
		.CYCLES_PER_LINE (CYCLES_PER_LINE)
	) u_timer (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (acc),
		.tick        (is_tick),
		.clr_pending (is_srd),
		.cycles      (in_item.tick_cycles),
		.reload      (regs_q[REG_LINE_CNT]),
		.stat        (tstat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q        <= '0;
			code_q        <= CODE_VRAM_RD;
			second_q      <= 1'b0;
			target_vram_q <= 1'b1;
			buf_q         <= '0;
			buf_mem_q     <= 1'b0;
			for (int i = 0; i < NUM_REGS; i++) begin
				regs_q[i] <= REG_RESET[i];
			end
		end else if (acc) begin
			case (in_item.mode)
				MODE_CTRL_WR: begin
					second_q <= !second_q;
					if (!second_q) begin
						addr_q[7:0] <= in_item.value;
					end else begin
						code_q        <= new_code;
						addr_q        <= new_addr;
						target_vram_q <= new_code != CODE_CRAM_WR;
						if (new_code == CODE_VRAM_RD) begin
							addr_q    <= new_addr + 1'b1;
							buf_mem_q <= 1'b1;
						end
						if (reg_we) begin
							regs_q[reg_idx] <= addr_q[7:0];
						end
					end
				end
				MODE_DATA_WR: begin
					second_q  <= 1'b0;
					addr_q    <= addr_q + 1'b1;
					buf_q     <= in_item.value;
					buf_mem_q <= 1'b0;
				end
				MODE_STAT_RD: begin
					second_q <= 1'b0;
				end
				MODE_DATA_RD: begin
					second_q  <= 1'b0;
					addr_q    <= addr_q + 1'b1;
					buf_mem_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	assign r0_b4 = (reg_we && reg_idx == REG_MODE1) ? addr_q[4] : regs_q[REG_MODE1][4];
	assign r1_b5 = (reg_we && reg_idx == REG_MODE2) ? addr_q[5] : regs_q[REG_MODE2][5];

	always_comb begin
		res.read_data = '0;
		if (is_srd) begin
			res.read_data = {tstat.frame_irq_now, 2'b00, STATUS_FIXED};
		end else if (is_drd) begin
			res.read_data = buf_now;
		end
		res.irq_line     = (tstat.frame_irq && r1_b5) || (tstat.line_irq && r0_b4);
		res.vcount_value = tstat.vcount;
		res.frame_done   = tstat.done;
	end

	vdpt_out_buf u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (acc),
		.din      (res),
		.full     (full),
		.out_item (out_item)
	);

	a_done_vcount_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_item.valid && out_item.frame_done |-> out_item.vcount_value == 8'd0)
		else $error("frame_done result with nonzero vertical count");

	a_status_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && is_srd |-> !tstat.line_irq && !tstat.frame_irq && !res.irq_line)
		else $error("status read left an interrupt pending");

	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !acc && !vram_rd)
		else $error("item accepted during VRAM clear");

	a_code_kept: assert property (@(posedge clk) disable iff (!arst_n)
		acc && (is_dwr || is_drd) |=> $stable(code_q))
		else $error("address advance changed the code bits");
endmodule

@@ test/vdpt_port_checker.sv @@
`timescale 1ns / 100ps

module vdpt_port_checker #(
	parameter int CYCLES_PER_LINE = vdpt_pkg::CYCLES_PER_LINE_DEF
) (
	input  logic clk,
	input  logic arst_n,
	vdpt_in_if   in_mon,
	vdpt_out_if  out_mon,
	output int   fail_count,
	output int   pending
);
	import vdpt_pkg::*;

	logic [7:0]  vram_img [VRAM_DEPTH];
	logic [7:0]  cram_img [32];
	logic [7:0]  vdp_regs [NUM_REGS];
	logic [15:0] cmd_word;
	logic        second_half;
	logic        to_vram;
	logic [7:0]  rd_buf;
	logic [8:0]  cyc_accum;
	logic [8:0]  line_num;
	logic [7:0]  vcount;
	logic [7:0]  line_down;
	logic        line_irq_flag;
	logic        frame_irq_flag;
	result_t     awaited_port_results [$];

	function automatic void clear_vdp_state();
		foreach (vram_img[i])
			vram_img[i] = 8'h00;
		foreach (cram_img[i])
			cram_img[i] = 8'h00;
		foreach (vdp_regs[i])
			vdp_regs[i] = REG_RESET[i];
		cmd_word       = '0;
		second_half    = 1'b0;
		to_vram        = 1'b1;
		rd_buf         = '0;
		cyc_accum      = '0;
		line_num       = '0;
		vcount         = '0;
		line_down      = 8'hFF;
		line_irq_flag  = 1'b0;
		frame_irq_flag = 1'b0;
	endfunction

	// The address wraps within 14 bits and the code bits stay put.
	function automatic void step_address();
		cmd_word = {cmd_word[15:14], cmd_word[13:0] + 14'd1};
	endfunction

	function automatic void scan_one_line(ref result_t r);
		if (line_num <= LINE_ACTIVE_LAST) begin
			line_down = line_down - 8'd1;
			if (line_down == 8'hFF) begin
				line_down     = vdp_regs[REG_LINE_CNT];
				line_irq_flag = 1'b1;
			end
		end
		cyc_accum = cyc_accum - 9'(CYCLES_PER_LINE);
		line_num  = line_num + 9'd1;
		vcount    = vcount + 8'd1;
		if (line_num >= LINE_VBL_FIRST && line_num <= LINE_RELOAD_LAST)
			line_down = vdp_regs[REG_LINE_CNT];
		if (line_num == LINE_FRAME_IRQ) begin
			frame_irq_flag = 1'b1;
		end else if (line_num == LINE_JUMP) begin
			vcount = VCOUNT_JUMP;
		end else if (line_num == LINE_WRAP) begin
			r.frame_done = 1'b1;
			line_num     = '0;
			vcount       = '0;
		end
	endfunction

	function automatic result_t vdp_port_step(logic [MODE_W-1:0] mode, logic [7:0] value,
		logic [7:0] cyc);
		result_t    r;
		logic [9:0] sum;
		r = '0;
		case (mode)
			MODE_CTRL_WR: begin
				if (!second_half) begin
					second_half   = 1'b1;
					cmd_word[7:0] = value;
				end else begin
					second_half    = 1'b0;
					cmd_word[15:8] = value;
					case (value[7:6])
						CODE_VRAM_RD: begin
							rd_buf = vram_img[cmd_word[13:0]];
							step_address();
							to_vram = 1'b1;
						end
						CODE_VRAM_WR: begin
							to_vram = 1'b1;
						end
						CODE_REG_WR: begin
							if (value[3:0] < NUM_REGS)
								vdp_regs[value[3:0]] = cmd_word[7:0];
							to_vram = 1'b1;
						end
						default: begin
							to_vram = 1'b0;
						end
					endcase
				end
			end
			MODE_DATA_WR: begin
				second_half = 1'b0;
				if (to_vram)
					vram_img[cmd_word[13:0]] = value;
				else
					cram_img[cmd_word[4:0]] = value;
				step_address();
				rd_buf = value;
			end
			MODE_STAT_RD: begin
				r.read_data    = {frame_irq_flag, 2'b00, STATUS_FIXED};
				second_half    = 1'b0;
				line_irq_flag  = 1'b0;
				frame_irq_flag = 1'b0;
			end
			MODE_DATA_RD: begin
				r.read_data = rd_buf;
				second_half = 1'b0;
				rd_buf      = vram_img[cmd_word[13:0]];
				step_address();
			end
			MODE_TICK: begin
				sum = 10'(cyc_accum) + 10'(cyc);
				if (sum > 10'(ACCUM_MAX))
					sum = 10'(ACCUM_MAX);
				cyc_accum = sum[8:0];
				// At most one scanline per tick; the rest stays accumulated.
				if (cyc_accum >= 9'(CYCLES_PER_LINE))
					scan_one_line(r);
			end
			default: begin
			end
		endcase
		r.irq_line = (frame_irq_flag & vdp_regs[REG_MODE2][5]) |
			(line_irq_flag & vdp_regs[REG_MODE1][4]);
		r.vcount_value = vcount;
		return r;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			clear_vdp_state();
			awaited_port_results.delete();
			fail_count = 0;
		end else begin
			if (in_mon.valid && in_mon.ready)
				awaited_port_results.push_back(vdp_port_step(in_mon.mode, in_mon.value,
					in_mon.tick_cycles));
			if (out_mon.valid && out_mon.ready) begin
				if (awaited_port_results.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected, actual %02h %0b %02h %0b",
						$time, out_mon.read_data, out_mon.irq_line, out_mon.vcount_value,
						out_mon.frame_done);
				end else begin
					want = awaited_port_results.pop_front();
					check_field("read_data", want.read_data, out_mon.read_data);
					check_field("irq_line", want.irq_line, out_mon.irq_line);
					check_field("vcount_value", want.vcount_value, out_mon.vcount_value);
					check_field("frame_done", want.frame_done, out_mon.frame_done);
				end
			end
		end
		pending = awaited_port_results.size();
	end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import vdpt_pkg::*;

	localparam int ITEM_COUNT  = 1150;
	localparam int CYCLE_LIMIT = 200000;

	logic clk         = 1'b0;
	logic arst_n      = 1'b0;
	logic in_taken    = 1'b0;
	int   gap_pct     = 0;
	int   stall_pct   = 0;
	int   items_sent  = 0;
	int   cycle_count = 0;
	int   fail_count;
	int   pending;

	vdpt_in_if  in_bus ();
	vdpt_out_if out_bus ();

	video_chip_port_and_line_timing dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_item  (in_bus),
		.out_item (out_bus)
	);

	vdpt_port_checker port_watch (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_mon     (in_bus),
		.out_mon    (out_bus),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #2 clk = ~clk;

	// Sampled at the rising edge, read by the sender at the next falling edge.
	always @(posedge clk)
		in_taken = in_bus.valid && in_bus.ready;

	always @(negedge clk)
		out_bus.ready = ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("video_chip_port_and_line_timing verification failed");
			$finish;
		end
	end

	task automatic send_item(logic [MODE_W-1:0] mode, logic [7:0] value, logic [7:0] cyc);
		while ($urandom_range(99) < gap_pct) begin
			in_bus.valid = 1'b0;
			in_bus.value = 8'($urandom);
			@(negedge clk);
		end
		in_bus.valid       = 1'b1;
		in_bus.mode        = mode;
		in_bus.value       = value;
		in_bus.tick_cycles = cyc;
		do @(negedge clk); while (!in_taken);
		if (mode <= MODE_TICK)
			items_sent++;
	endtask

	task automatic send_ctrl_pair(logic [13:0] addr, logic [1:0] code);
		send_item(MODE_CTRL_WR, addr[7:0], 8'($urandom));
		send_item(MODE_CTRL_WR, {code, addr[13:8]}, 8'($urandom));
	endtask

	task automatic send_reg_write(logic [3:0] idx, logic [7:0] data);
		send_item(MODE_CTRL_WR, data, 8'($urandom));
		send_item(MODE_CTRL_WR, {CODE_REG_WR, 2'($urandom), idx}, 8'($urandom));
	endtask

	function automatic logic [13:0] pick_addr();
		case ($urandom_range(3))
			0: return 14'($urandom);
			1: return 14'h3FF8 + 14'($urandom_range(7));
			default: return 14'($urandom_range(31));
		endcase
	endfunction

	initial begin
		int         roll;
		int         phase;
		logic [3:0] idx;
		in_bus.valid       = 1'b0;
		in_bus.mode        = MODE_CTRL_WR;
		in_bus.value       = 8'h00;
		in_bus.tick_cycles = 8'h00;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		send_item(MODE_STAT_RD, 8'h00, 8'h00);
		// A lone first control byte is dropped by the data read that follows.
		send_item(MODE_CTRL_WR, 8'h55, 8'h00);
		send_item(MODE_DATA_RD, 8'h00, 8'h00);
		// Writes run past the top of VRAM and wrap to address zero.
		send_ctrl_pair(14'h3FFE, CODE_VRAM_WR);
		send_item(MODE_DATA_WR, 8'hA5, 8'h00);
		send_item(MODE_DATA_WR, 8'h5A, 8'h00);
		send_item(MODE_DATA_WR, 8'hFF, 8'h00);
		send_ctrl_pair(14'h3FFE, CODE_VRAM_RD);
		send_item(MODE_DATA_RD, 8'h00, 8'h00);
		send_item(MODE_DATA_RD, 8'h00, 8'h00);
		send_ctrl_pair(14'h0025, CODE_CRAM_WR);
		send_item(MODE_DATA_WR, 8'h3C, 8'h00);
		send_reg_write(4'd11, 8'h12);
		send_reg_write(REG_MODE2, 8'hE0);
		send_reg_write(REG_MODE1, 8'h16);
		send_reg_write(REG_LINE_CNT, 8'h00);
		for (int m = MODE_TICK + 1; m < 8; m++)
			send_item(MODE_W'(m), 8'hFF, 8'hFF);
		// Back-to-back full ticks drive the cycle sum into saturation.
		send_item(MODE_TICK, 8'h00, 8'h00);
		repeat (12) send_item(MODE_TICK, 8'h00, 8'hFF);

		while (items_sent < ITEM_COUNT) begin
			phase = (items_sent / 100) % 4;
			case (phase)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 67; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 67; end
				default: begin gap_pct = 30; stall_pct = 30; end
			endcase
			roll = $urandom_range(99);
			if (roll < 38) begin
				repeat ($urandom_range(1, 8))
					send_item(MODE_TICK, 8'($urandom), ($urandom_range(99) < 85) ?
						8'($urandom_range(228, 255)) : 8'($urandom));
			end else if (roll < 52) begin
				send_ctrl_pair(pick_addr(), CODE_VRAM_WR);
				repeat ($urandom_range(1, 4))
					send_item(MODE_DATA_WR, 8'($urandom), 8'($urandom));
			end else if (roll < 62) begin
				send_ctrl_pair(pick_addr(), CODE_VRAM_RD);
				repeat ($urandom_range(1, 4))
					send_item(MODE_DATA_RD, 8'($urandom), 8'($urandom));
			end else if (roll < 66) begin
				send_ctrl_pair(14'($urandom), CODE_CRAM_WR);
				repeat ($urandom_range(1, 3))
					send_item(MODE_DATA_WR, 8'($urandom), 8'($urandom));
			end else if (roll < 74) begin
				case ($urandom_range(3))
					0: idx = REG_MODE1;
					1: idx = REG_MODE2;
					2: idx = REG_LINE_CNT;
					default: idx = 4'($urandom);
				endcase
				send_reg_write(idx, (idx == REG_LINE_CNT && $urandom_range(1)) ?
					8'($urandom_range(15)) : 8'($urandom));
			end else if (roll < 86) begin
				send_item(MODE_STAT_RD, 8'($urandom), 8'($urandom));
			end else begin
				send_item(MODE_W'($urandom), 8'($urandom), 8'($urandom));
			end
		end
		in_bus.valid = 1'b0;

		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0)
			$display("video_chip_port_and_line_timing verification clean");
		else
			$display("video_chip_port_and_line_timing verification failed");
		$finish;
	end

endmodule
